/* rtl/lsp_pkg.sv */
package lsp_pkg;

    localparam int DIST_W  = 16;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = 2;
    localparam int TDATA_W = 24;
    localparam int Q6_W    = 15;

    // Configuration register indexes
    localparam logic CFG_MODE      = 1'b0;
    localparam logic CFG_MAX_RANGE = 1'b1;

    // Mode codes (mode 3 behaves as idle)
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_STD   = 2'd1;
    localparam logic [1:0] MODE_DENSE = 2'd2;

    localparam logic [15:0] MAX_RANGE_RST = 16'd12000;

    // Standard scan angle in fifths of a degree
    localparam logic [10:0] FIFTHS_STEP = 11'd18;
    localparam logic [10:0] FIFTHS_FULL = 11'd1800;
    // Dense start angle in steps of 0.1125 degree
    localparam logic [11:0] STEPS_FULL  = 12'd3200;

    localparam logic [5:0] SCAN_QUALITY = 6'd17;
    localparam logic [3:0] SYNC_HI      = 4'hA;
    localparam logic [3:0] SYNC_LO      = 4'h5;

    // Output word selector
    typedef logic [2:0] sel_t;
    localparam sel_t SEL_STD0  = 3'd0;
    localparam sel_t SEL_STD1  = 3'd1;
    localparam sel_t SEL_STD2  = 3'd2;
    localparam sel_t SEL_SYNC  = 3'd3;
    localparam sel_t SEL_ANGLE = 3'd4;
    localparam sel_t SEL_RANGE = 3'd5;

    typedef struct packed {
        logic take_std;   // latch sample, advance scan angle
        logic take_dense; // store sample, update checksum and slot
        logic emit;       // load output register
        sel_t sel;        // which word to load
        logic rd_first;   // read first buffered range
        logic rd_next;    // read following buffered range
        logic pkt_done;   // advance start angle, clear slot and checksum
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       slot_last; // the next stored sample fills the packet
        logic       rd_last;   // the range being emitted is the final one
        logic       out_free;  // output register can take a word
    } sts_t;

    // floor(x / 5) for 17-bit x, by reciprocal multiply
    function automatic logic [Q6_W-1:0] div5(input logic [16:0] x);
        logic [36:0] prod;
        prod = {20'd0, x} * 37'd838861;
        return prod[22 +: Q6_W];
    endfunction

endpackage

/* rtl/lsp_ram.sv */
module lsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lsp_ctrl.sv */
module lsp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lsp_pkg::sts_t sts,
    output lsp_pkg::cmd_t cmd
);
    import lsp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STD0  = 3'd1;
    localparam logic [2:0] S_STD1  = 3'd2;
    localparam logic [2:0] S_STD2  = 3'd3;
    localparam logic [2:0] S_SYNC  = 3'd4;
    localparam logic [2:0] S_ANGLE = 3'd5;
    localparam logic [2:0] S_RANGE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_STD0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (sts.mode == MODE_STD)
                    begin
                        cmd.take_std = 1'b1;
                        state_next   = S_STD0;
                    end
                    else if (sts.mode == MODE_DENSE)
                    begin
                        cmd.take_dense = 1'b1;
                        if (sts.slot_last)
                        begin
                            state_next = S_SYNC;
                        end
                    end
                end
            end
            S_STD0:
            begin
                cmd.sel = SEL_STD0;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_STD1;
                end
            end
            S_STD1:
            begin
                cmd.sel = SEL_STD1;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_STD2;
                end
            end
            S_STD2:
            begin
                cmd.sel = SEL_STD2;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SYNC:
            begin
                cmd.sel = SEL_SYNC;
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.rd_first = 1'b1;
                    state_next   = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                cmd.sel = SEL_ANGLE;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                cmd.sel = SEL_RANGE;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.rd_last)
                    begin
                        cmd.pkt_done = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lsp_dp.sv */
module lsp_dp #(
    parameter int SAMPLES_PER_PACKET = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic [lsp_pkg::DIST_W-1:0]    distance_mm,
    input  logic                          out_take,
    input  lsp_pkg::cmd_t                 cmd,
    output lsp_pkg::sts_t                 sts,
    output logic                          out_valid,
    output logic [lsp_pkg::WORD_W-1:0]    out_word,
    output logic [lsp_pkg::CNT_W-1:0]     out_count,
    output logic                          out_last
);
    import lsp_pkg::*;

    localparam int AW = $clog2(SAMPLES_PER_PACKET);
    localparam int SW = $clog2(SAMPLES_PER_PACKET + 1);

    logic [1:0]        mode_reg;
    logic [15:0]       max_range_reg;
    logic [10:0]       fifths_reg, fifths_next;
    logic              start_reg;
    logic [11:0]       steps_reg, steps_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [7:0]        xor_reg, xor_next;
    logic [15:0]       range_reg;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;

    logic [15:0]       clamped;
    logic [11:0]       fifths_sum;
    logic [12:0]       steps_sum;
    logic [16:0]       dividend;
    logic [Q6_W-1:0]   q6;
    logic [15:0]       q2;
    logic [7:0]        cs;
    logic [15:0]       ram_rdata;
    logic [AW-1:0]     ram_raddr;
    logic              mode_wr;

    assign clamped    = (distance_mm > max_range_reg) ? 16'd0 : distance_mm;
    assign fifths_sum = {1'b0, fifths_reg} + {1'b0, FIFTHS_STEP};
    assign steps_sum  = {1'b0, steps_reg} + 13'(SAMPLES_PER_PACKET);
    assign mode_wr    = cfg_we && (cfg_index == CFG_MODE);

    // One shared divide-by-five for both angle encodings
    assign dividend = (mode_reg == MODE_DENSE)
                    ? ({5'd0, steps_reg} << 5) + ({5'd0, steps_reg} << 2) + 17'd2
                    : {fifths_reg, 6'd0};
    assign q6 = div5(dividend);
    assign q2 = (range_reg[15:14] != 2'b00) ? 16'hFFFF : {range_reg[13:0], 2'b00};
    assign cs = xor_reg ^ q6[7:0] ^ {1'b0, q6[14:8]};

    assign ram_raddr = cmd.rd_first ? '0 : rd_idx_reg + AW'(1);

    lsp_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLES_PER_PACKET)
    ) u_store (
        .clk   (clk),
        .we    (cmd.take_dense),
        .waddr (slot_reg[AW-1:0]),
        .wdata (clamped),
        .re    (cmd.rd_first || cmd.rd_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fifths_next = fifths_reg;
        steps_next  = steps_reg;
        slot_next   = slot_reg;
        xor_next    = xor_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.take_std)
        begin
            fifths_next = (fifths_sum >= {1'b0, FIFTHS_FULL})
                        ? 11'(fifths_sum - {1'b0, FIFTHS_FULL}) : fifths_sum[10:0];
        end
        if (cmd.take_dense)
        begin
            slot_next = slot_reg + SW'(1);
            xor_next  = xor_reg ^ clamped[7:0] ^ clamped[15:8];
        end
        if (cmd.rd_first)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
        if (cmd.pkt_done)
        begin
            steps_next = (steps_sum >= {1'b0, STEPS_FULL})
                       ? 12'(steps_sum - {1'b0, STEPS_FULL}) : steps_sum[11:0];
            slot_next  = '0;
            xor_next   = '0;
        end
        if (mode_wr)
        begin
            fifths_next = '0;
            steps_next  = '0;
            slot_next   = '0;
            xor_next    = '0;
        end
    end

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        case (cmd.sel)
            SEL_STD0:
            begin
                word_next = {q6[6:0], 1'b1, SCAN_QUALITY, ~start_reg, start_reg};
                cnt_next  = 2'd2;
                last_next = 1'b0;
            end
            SEL_STD1:
            begin
                word_next = {q2[7:0], q6[14:7]};
                cnt_next  = 2'd2;
                last_next = 1'b0;
            end
            SEL_STD2:
            begin
                word_next = {8'd0, q2[15:8]};
                cnt_next  = 2'd1;
                last_next = 1'b1;
            end
            SEL_SYNC:
            begin
                word_next = {SYNC_LO, cs[7:4], SYNC_HI, cs[3:0]};
                cnt_next  = 2'd2;
                last_next = 1'b0;
            end
            SEL_ANGLE:
            begin
                word_next = {1'b0, q6};
                cnt_next  = 2'd2;
                last_next = 1'b0;
            end
            SEL_RANGE:
            begin
                word_next = ram_rdata;
                cnt_next  = 2'd2;
                last_next = (rd_idx_reg == AW'(SAMPLES_PER_PACKET - 1));
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (out_take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            max_range_reg <= MAX_RANGE_RST;
            fifths_reg    <= '0;
            steps_reg     <= '0;
            slot_reg      <= '0;
            xor_reg       <= '0;
            rd_idx_reg    <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (mode_wr)
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_we && (cfg_index == CFG_MAX_RANGE))
            begin
                max_range_reg <= cfg_data;
            end
            fifths_reg <= fifths_next;
            steps_reg  <= steps_next;
            slot_reg   <= slot_next;
            xor_reg    <= xor_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_std)
        begin
            range_reg <= clamped;
            start_reg <= (fifths_sum >= {1'b0, FIFTHS_FULL});
        end
        if (cmd.emit)
        begin
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    assign sts.mode      = mode_reg;
    assign sts.slot_last = (slot_reg == SW'(SAMPLES_PER_PACKET - 1));
    assign sts.rd_last   = (rd_idx_reg == AW'(SAMPLES_PER_PACKET - 1));
    assign sts.out_free  = !valid_reg || out_take;

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_count = cnt_reg;
    assign out_last  = last_reg;

endmodule

/* rtl/lidar_sample_packetizer.sv */
// Lidar sample packetizer: turns range samples into the sensor's serial stream.
// Slave stream (s_*): one range sample in millimetres per request.
// Master stream (m_*): one 16-bit little-endian word per request, with a byte
// count (1 or 2) and tlast on the final word of a record or packet.
// Config port: cfg_we/cfg_index/cfg_data, index 0 = mode (0 idle, 1 standard,
// 2 dense express), index 1 = maximum range. Writing mode clears all angles,
// the buffered-sample count and the checksum. Write only while the block idles.
// Idle mode: a sample is taken and dropped.
// Standard mode: a sample is taken, then three words follow one per cycle
// when the receiver keeps up.
// Dense mode: each sample is stored into the range buffer RAM; the sample that
// fills the buffer starts a packet of SAMPLES_PER_PACKET + 2 words at one word
// per cycle when the receiver keeps up. The buffer RAM's registered read port
// is fetched one word ahead of the output.
// No sample is accepted while words of a record or packet are still being
// produced; the sequencer walks one word at a time through the controller.
// A stalled receiver holds the output register; the sequencer waits on it
// without losing or repeating words. The next sample is accepted while the
// final word still waits in the output register.
// Reset: idle mode, maximum range 12000, angles and counts cleared.
module lidar_sample_packetizer #(
    parameter int SAMPLES_PER_PACKET = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsp_pkg::DIST_W-1:0]    s_tdata,   // [15:0] distance_mm
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsp_pkg::TDATA_W-1:0]   m_tdata,   // [15:0] word, [17:16] byte_count
    output logic                          m_tlast
);
    import lsp_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [WORD_W-1:0] out_word;
    logic [CNT_W-1:0]  out_count;

    // Sequencer: sample intake and word ordering
    lsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Angles, checksum, range buffer and the output register
    lsp_dp #(
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .distance_mm (s_tdata),
        .out_take    (m_tready),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_word    (out_word),
        .out_count   (out_count),
        .out_last    (m_tlast)
    );

    // Pack word and byte count, pad to whole bytes
    assign m_tdata = {{(TDATA_W - WORD_W - CNT_W){1'b0}}, out_count, out_word};

endmodule
